FILE: hw/rtl/log_url_extract_hash_assert.svh
// assertion helpers, clocked on aclk, off while aresetn is low
`ifndef LOG_URL_EXTRACT_HASH_ASSERT_SVH
`define LOG_URL_EXTRACT_HASH_ASSERT_SVH

// same-cycle implication
`define LUE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LUE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lue_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lue_pkg;

    localparam int BUCKETS_DEF       = 131071;
    localparam int MAX_URL_BYTES_DEF = 128;

    localparam logic [7:0]  NUL_CHAR   = 8'h00;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  QUOTE_CHAR = 8'h22;
    localparam logic [63:0] HASH_START = 64'd5381;

    localparam int BUCKET_W = 17;
    localparam int LEN_W    = 7;

    // hash is folded as eight bytes, each times 2^(8k) mod buckets
    localparam int FOLD_CHUNKS = 8;
    localparam int CHUNK_W     = 8;
    localparam int SUM_GROWTH  = $clog2(FOLD_CHUNKS);
    // restoring reduction of the folded sum: quotient bits to resolve
    localparam int RED_STEPS   = CHUNK_W + SUM_GROWTH + 1;
    localparam int RED_PER_STG = 4;
    localparam int RED_STAGES  = RED_STEPS / RED_PER_STG;

    typedef enum logic [1:0] {
        PH_QUOTE = 2'd0,
        PH_SPACE = 2'd1,
        PH_URL   = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic               found;
        logic [63:0]        hash;
        logic [LEN_W-1:0]   len;
    } launch_t;

    // 2^(8*idx) mod buckets, by doubling and conditional subtract (buckets >= 2)
    function automatic int fold_residue(input int buckets, input int idx);
        int r;
        r = 1;
        for (int i = 0; i < CHUNK_W * idx; i++) begin
            r = r * 2;
            if (r >= buckets) begin
                r = r - buckets;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lue_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lue_scan #(
    parameter int MAX_URL_BYTES = lue_pkg::MAX_URL_BYTES_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      line_byte,
    input  wire logic            end_of_line,
    output logic                 launch_valid,
    output lue_pkg::launch_t     launch
);

    localparam logic [7:0] MAX_CNT = 8'(MAX_URL_BYTES);

    lue_pkg::phase_t phase_reg, phase_step, phase_next;
    logic [63:0]     hash_reg, hash_step, hash_next;
    logic [7:0]      count_reg, count_step, count_next;
    logic            url_ok;

    always_comb begin
        phase_step = phase_reg;
        hash_step  = hash_reg;
        count_step = count_reg;
        if (line_byte == lue_pkg::NUL_CHAR && phase_reg != lue_pkg::PH_DONE) begin
            phase_step = lue_pkg::PH_DONE;
            count_step = 8'd0;
        end else begin
            case (phase_reg)
                lue_pkg::PH_QUOTE: begin
                    if (line_byte == lue_pkg::QUOTE_CHAR) begin
                        phase_step = lue_pkg::PH_SPACE;
                    end
                end
                lue_pkg::PH_SPACE: begin
                    if (line_byte == lue_pkg::SPACE_CHAR) begin
                        phase_step = lue_pkg::PH_URL;
                        hash_step  = lue_pkg::HASH_START;
                        count_step = 8'd0;
                    end
                end
                lue_pkg::PH_URL: begin
                    if (line_byte == lue_pkg::SPACE_CHAR) begin
                        phase_step = lue_pkg::PH_DONE;
                    end else begin
                        hash_step = (hash_reg << 5) + hash_reg
                                  + {{56{line_byte[7]}}, line_byte};
                        if (count_reg < MAX_CNT) begin
                            count_step = count_reg + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (end_of_line) begin
            phase_next = lue_pkg::PH_QUOTE;
            hash_next  = lue_pkg::HASH_START;
            count_next = 8'd0;
        end else begin
            phase_next = phase_step;
            hash_next  = hash_step;
            count_next = count_step;
        end
    end

    always_comb begin
        url_ok = (phase_step == lue_pkg::PH_DONE) && (count_step != 8'd0)
               && (count_step < MAX_CNT);
        launch_valid = accept && end_of_line;
        launch.found = url_ok;
        launch.hash  = url_ok ? hash_step : 64'd0;
        launch.len   = url_ok ? count_step[lue_pkg::LEN_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lue_pkg::PH_QUOTE;
            hash_reg  <= lue_pkg::HASH_START;
            count_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hash_reg  <= hash_next;
            count_reg <= count_next;
        end
    end

`include "log_url_extract_hash_assert.svh"

    `LUE_ASSERT_NXT(a_line_clears, accept && end_of_line, phase_reg == lue_pkg::PH_QUOTE && count_reg == 8'd0, "line end did not clear scan state")
    `LUE_ASSERT_NXT(a_nul_done, accept && !end_of_line && line_byte == lue_pkg::NUL_CHAR, phase_reg == lue_pkg::PH_DONE, "zero byte did not end the scan")

endmodule

`default_nettype wire

FILE: hw/rtl/lue_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module lue_mod #(
    parameter int BUCKETS = lue_pkg::BUCKETS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lue_pkg::launch_t              in_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               out_found,
    output logic [lue_pkg::BUCKET_W-1:0]       out_bucket,
    output logic [lue_pkg::LEN_W-1:0]          out_len
);

    localparam int BW   = $clog2(BUCKETS);
    localparam int PW   = lue_pkg::CHUNK_W + BW;
    localparam int XW   = BW + lue_pkg::CHUNK_W + lue_pkg::SUM_GROWTH;
    localparam int RSTG = lue_pkg::RED_STAGES;
    localparam int SPS  = lue_pkg::RED_PER_STG;
    localparam int NST  = 3 + RSTG;
    localparam logic [XW:0] BK = (XW + 1)'(BUCKETS);

    logic [NST-1:0]             valid_reg;
    logic [NST:0]               rdy;
    logic                       found_reg [NST];
    logic [lue_pkg::LEN_W-1:0]  len_reg   [NST];

    logic [63:0]                hash_reg;
    logic [PW-1:0]              prod_reg  [lue_pkg::FOLD_CHUNKS];
    logic [PW-1:0]              prod_next [lue_pkg::FOLD_CHUNKS];
    logic [XW-1:0]              sum_reg, sum_next;
    logic [XW-1:0]              red_reg   [RSTG];
    logic [XW-1:0]              red_next  [RSTG];

    always_comb begin
        rdy[NST] = m_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NST; i++) begin
            if (rdy[i]) begin
                found_reg[i] <= (i == 0) ? in_item.found : found_reg[(i == 0) ? 0 : i - 1];
                len_reg[i]   <= (i == 0) ? in_item.len   : len_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // fold: sum of byte k times 2^(8k) mod buckets
    for (genvar k = 0; k < lue_pkg::FOLD_CHUNKS; k++) begin : g_fold
        localparam int RK = lue_pkg::fold_residue(BUCKETS, k);
        assign prod_next[k] = PW'(hash_reg[k*lue_pkg::CHUNK_W +: lue_pkg::CHUNK_W])
                            * PW'(RK);
    end

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < lue_pkg::FOLD_CHUNKS; k++) begin
            sum_next = sum_next + XW'(prod_reg[k]);
        end
    end

    // restoring reduction, SPS quotient bits per stage
    for (genvar s = 0; s < RSTG; s++) begin : g_red
        logic [XW:0] acc;
        always_comb begin
            acc = (s == 0) ? {1'b0, sum_reg} : {1'b0, red_reg[(s == 0) ? 0 : s - 1]};
            for (int k = 0; k < SPS; k++) begin
                if (acc >= (BK << (lue_pkg::RED_STEPS - 1 - s * SPS - k))) begin
                    acc = acc - (BK << (lue_pkg::RED_STEPS - 1 - s * SPS - k));
                end
            end
            red_next[s] = acc[XW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            hash_reg <= in_item.hash;
        end
        if (rdy[1]) begin
            prod_reg <= prod_next;
        end
        if (rdy[2]) begin
            sum_reg <= sum_next;
        end
        for (int s = 0; s < RSTG; s++) begin
            if (rdy[3+s]) begin
                red_reg[s] <= red_next[s];
            end
        end
    end

    assign m_valid    = valid_reg[NST-1];
    assign out_found  = found_reg[NST-1];
    assign out_len    = len_reg[NST-1];
    assign out_bucket = lue_pkg::BUCKET_W'(red_reg[RSTG-1][BW-1:0]);

`include "log_url_extract_hash_assert.svh"

    `LUE_ASSERT_NXT(a_enter, in_valid && in_ready, valid_reg[0], "launched word not captured")
    `LUE_ASSERT_IMP(a_found_len, m_valid && out_found, out_len != '0, "found URL with zero length")
    `LUE_ASSERT_IMP(a_bucket_range, m_valid, out_bucket < lue_pkg::BUCKET_W'(BUCKETS), "bucket out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/log_url_extract_hash.sv
// URL extractor and djb2 hasher. Takes one log-line byte per clock while
// s_ready is high; the byte marked end_of_line yields one result word (found
// flag, 17-bit bucket of the 64-bit djb2 hash modulo BUCKETS, URL length).
// The scanner state updates in the cycle a byte is taken, and the bucket is
// produced by a six-stage pipeline (hash capture, byte fold, fold sum, three
// restoring-reduction stages), so a new line may end on every clock while
// m_ready keeps the pipeline moving. s_ready drops only when all six result
// stages hold words and m_ready is low. No clearing pass is needed after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module log_url_extract_hash #(
    parameter int BUCKETS       = lue_pkg::BUCKETS_DEF,
    parameter int MAX_URL_BYTES = lue_pkg::MAX_URL_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_line_byte,
    input  wire logic                          s_end_of_line,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_url_found,
    output logic [lue_pkg::BUCKET_W-1:0]       m_bucket_index,
    output logic [lue_pkg::LEN_W-1:0]          m_url_length
);

    logic             launch_valid;
    lue_pkg::launch_t launch;

    lue_scan #(
        .MAX_URL_BYTES (MAX_URL_BYTES)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_valid && s_ready),
        .line_byte    (s_line_byte),
        .end_of_line  (s_end_of_line),
        .launch_valid (launch_valid),
        .launch       (launch)
    );

    lue_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (launch_valid),
        .in_ready   (s_ready),
        .in_item    (launch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .out_found  (m_url_found),
        .out_bucket (m_bucket_index),
        .out_len    (m_url_length)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lue_pkg::*;

    localparam int RANDOM_BYTES = 1050;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic                found;
        logic [BUCKET_W-1:0] bucket;
        logic [LEN_W-1:0]    len;
    } url_result_t;

    typedef struct {
        logic [7:0] b;
        logic       eol;
        logic       miss;
    } probe_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_line_byte = 8'h00;
    logic              s_end_of_line = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_url_found;
    logic [BUCKET_W-1:0] m_bucket_index;
    logic [LEN_W-1:0]  m_url_length;

    phase_t            scan_phase = PH_QUOTE;
    logic [63:0]       url_hash = HASH_START;
    logic [7:0]        url_count = 8'd0;

    url_result_t       expected_urls[$];
    probe_row_t        probe_rows[$];
    logic [7:0]        line_buf[$];
    int                errors = 0;
    int                cycle_count = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;
    int                rx_stall_left = 0;

    log_url_extract_hash dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_byte    (s_line_byte),
        .s_end_of_line  (s_end_of_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_url_found    (m_url_found),
        .m_bucket_index (m_bucket_index),
        .m_url_length   (m_url_length)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // advances the URL scanner by one byte; returns 1 when the line closes
    function automatic bit scan_byte(input logic [7:0] b, input logic eol,
                                     output url_result_t r);
        logic [63:0] rem;
        if (b == NUL_CHAR && scan_phase != PH_DONE) begin
            scan_phase = PH_DONE;
            url_count  = 8'd0;
        end else begin
            case (scan_phase)
                PH_QUOTE: begin
                    if (b == QUOTE_CHAR) scan_phase = PH_SPACE;
                end
                PH_SPACE: begin
                    if (b == SPACE_CHAR) begin
                        scan_phase = PH_URL;
                        url_hash   = HASH_START;
                        url_count  = 8'd0;
                    end
                end
                PH_URL: begin
                    if (b == SPACE_CHAR) begin
                        scan_phase = PH_DONE;
                    end else begin
                        url_hash = (url_hash << 5) + url_hash + {{56{b[7]}}, b};
                        if (url_count < MAX_URL_BYTES_DEF) url_count = url_count + 8'd1;
                    end
                end
                default: ;
            endcase
        end
        r = '0;
        if (!eol) return 1'b0;
        if (scan_phase == PH_DONE && url_count != 0 && url_count < MAX_URL_BYTES_DEF) begin
            rem      = url_hash % 64'(BUCKETS_DEF);
            r.found  = 1'b1;
            r.bucket = rem[BUCKET_W-1:0];
            r.len    = url_count[LEN_W-1:0];
        end
        scan_phase = PH_QUOTE;
        url_hash   = HASH_START;
        url_count  = 8'd0;
        return 1'b1;
    endfunction

    function automatic int idle_span(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] plain_byte(input bit no_quote);
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(1, 255));
        end while (v == SPACE_CHAR || (no_quote && v == QUOTE_CHAR));
        return v;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return QUOTE_CHAR;
            1: return SPACE_CHAR;
            2: return NUL_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_probe(input logic [7:0] b, input logic eol, input logic miss);
        probe_row_t row;
        row.b    = b;
        row.eol  = eol;
        row.miss = miss;
        probe_rows.push_back(row);
    endtask

    // miss: the line is known to yield no URL, so the expectation is all zero
    task automatic push_byte(input logic [7:0] b, input logic eol, input logic miss);
        int idle;
        url_result_t r;
        idle = idle_span(tx_quiet);
        if (idle != 0) begin
            s_valid = 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_line_byte   = b;
        s_end_of_line = eol;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (scan_byte(b, eol, r)) expected_urls.push_back(miss ? url_result_t'('0) : r);
        @(negedge aclk);
    endtask

    task automatic drain_pause();
        s_valid = 1'b0;
        while (expected_urls.size() != 0) @(negedge aclk);
    endtask

    // mostly well-formed request lines; some with one flaw, some pure noise
    task automatic fill_line();
        int kind;
        int flaw;
        int n;
        int url_len;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(noise_byte());
            return;
        end
        flaw = (kind < 70) ? 0 : $urandom_range(1, 4);
        n = $urandom_range(0, 5);
        repeat (n) line_buf.push_back(plain_byte(1'b1));
        if (flaw != 1) line_buf.push_back(QUOTE_CHAR);
        n = $urandom_range(0, 4);
        repeat (n) line_buf.push_back(plain_byte(1'b0));
        line_buf.push_back(SPACE_CHAR);
        n = $urandom_range(0, 99);
        if (flaw == 2) url_len = 0;
        else if (n < 92) url_len = $urandom_range(1, 24);
        else if (n < 97) url_len = $urandom_range(100, 135);
        else url_len = $urandom_range(126, 129);
        for (int i = 0; i < url_len; i++) line_buf.push_back(plain_byte(1'b0));
        if (flaw == 3) line_buf.push_back(NUL_CHAR);
        if (flaw != 4) begin
            line_buf.push_back(SPACE_CHAR);
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(noise_byte());
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
            if (rx_stall_left != 0) begin
                m_ready = 1'b0;
                rx_stall_left = rx_stall_left - 1;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall_left = idle_span(rx_quiet);
            end
        end
    end

    always @(posedge aclk) begin
        url_result_t want;
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_urls.size() == 0) begin
                $display("%0t: unexpected word found=%0d bucket=%0d len=%0d", $time,
                         m_url_found, m_bucket_index, m_url_length);
                errors = errors + 1;
            end else begin
                want = expected_urls.pop_front();
                if (m_url_found !== want.found) begin
                    $display("%0t: url_found expected %0d got %0d", $time,
                             want.found, m_url_found);
                    errors = errors + 1;
                end
                if (m_bucket_index !== want.bucket) begin
                    $display("%0t: bucket_index expected %0d got %0d", $time,
                             want.bucket, m_bucket_index);
                    errors = errors + 1;
                end
                if (m_url_length !== want.len) begin
                    $display("%0t: url_length expected %0d got %0d", $time,
                             want.len, m_url_length);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        int sent;
        // no quote at all
        add_probe(8'h78, 1'b1, 1'b1);
        // empty URL
        add_probe(QUOTE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b1, 1'b1);
        // zero byte before any URL byte
        add_probe(QUOTE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(NUL_CHAR, 1'b1, 1'b1);
        // line ends inside the URL
        add_probe(QUOTE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(8'h62, 1'b1, 1'b1);
        // negative bytes, closed URL, then a zero byte that must be ignored
        add_probe(QUOTE_CHAR, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(8'hFF, 1'b0, 1'b0);
        add_probe(8'h80, 1'b0, 1'b0);
        add_probe(8'h01, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(NUL_CHAR, 1'b1, 1'b0);
        // space before the quote only
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(QUOTE_CHAR, 1'b1, 1'b1);
        // plain request
        add_probe(QUOTE_CHAR, 1'b0, 1'b0);
        add_probe(8'h47, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(8'h2F, 1'b0, 1'b0);
        add_probe(SPACE_CHAR, 1'b0, 1'b0);
        add_probe(8'h48, 1'b1, 1'b0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (probe_rows[i]) push_byte(probe_rows[i].b, probe_rows[i].eol, probe_rows[i].miss);

        drain_pause();
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
            if ($urandom_range(0, 24) == 0) drain_pause();
            fill_line();
            foreach (line_buf[i]) push_byte(line_buf[i], i == line_buf.size() - 1, 1'b0);
            sent = sent + line_buf.size();
        end

        s_valid = 1'b0;
        while (expected_urls.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
